// ----- src/pid_position_with_stall_stop_macros.svh -----
// Assertion macros for the position PID block.
`ifndef PID_POSITION_WITH_STALL_STOP_MACROS_SVH
`define PID_POSITION_WITH_STALL_STOP_MACROS_SVH

`ifndef SYNTH

// prop is checked on every rising clock edge outside reset
`define PWS_ASSERT(label, clk_s, rstn_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define PWS_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PWS_ASSERT(label, clk_s, rstn_s, prop, msg)
`define PWS_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg)

`endif

`endif

// ----- src/pidstall_pkg.sv -----
// Shared types, constants and divide helpers for the position PID block.
package pidstall_pkg;

    localparam int POS_W     = 10;
    localparam int OFS_W     = POS_W + 1;
    localparam int CUR_W     = 10;
    localparam int STR_W     = 8;
    localparam int GAIN_W    = 16;
    localparam int INT_W     = 32;
    localparam int CNT_W     = 4;
    localparam int DRIVE_W   = 10;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int STAGES    = 6;

    // intermediate widths of the drive pipeline
    localparam int Q_W     = 19;  // |sum| / 5000
    localparam int REM_W   = 13;  // remainder below 5000
    localparam int DQ_W    = 23;  // derivative quotient
    localparam int DIVIN_W = 29;  // input of the divide-by-625 helper

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_MOVE_ABS = 3'd1,
        OP_MOVE_REL = 3'd2,
        OP_MOVE_HIT = 3'd3,
        OP_STOP     = 3'd4
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_END = 2'd3;

    localparam logic [POS_W-1:0]   TRAVEL_END_RST = 10'd1023;
    localparam logic [CUR_W-1:0]   CUR_VALID_MAX  = 10'd180;
    localparam logic [STR_W-1:0]   LIMIT_RST      = 8'd50;
    localparam logic [CNT_W-1:0]   TRIPS_RST      = 4'd3;
    localparam logic [STR_W-1:0]   LIMIT_ARMED    = 8'd80;
    localparam logic [CNT_W-1:0]   TRIPS_ARMED    = 4'd5;
    localparam logic [CNT_W-1:0]   COUNT_MAX      = 4'd15;
    localparam logic [REM_W-1:0]   I_DIVISOR      = 13'd5000;
    localparam logic signed [DRIVE_W-1:0] DRIVE_LIM = 10'sd400;

    // state-update result for one accepted beat
    typedef struct packed {
        logic                    calc;     // tick with nonzero error
        logic signed [POS_W:0]   err;
        logic signed [INT_W-1:0] sum;
        logic signed [POS_W+1:0] derr;
        logic [POS_W-1:0]        target;
        logic                    tripped;
        logic                    limit;
    } item_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic [POS_W-1:0]          target_now;
        logic                      stall_stopped;
        logic                      limit_active;
    } result_t;

    // floor(x / 625), exact for x < 625 * 2^19, where the quotient fits Q_W bits
    function automatic logic [Q_W-1:0] div625(input logic [DIVIN_W-1:0] x);
        logic [58:0] p;
        p = x * 30'd879609303;
        return p[57:39];
    endfunction

    // floor(x / 25), exact for x < 2^27
    function automatic logic [DQ_W-1:0] div25(input logic [26:0] x);
        logic [54:0] p;
        p = x * 28'd171798692;
        return p[54:32];
    endfunction

endpackage

// ----- src/pidstall_cmd_if.sv -----
// Command channel: one operation beat with its sensor samples.
interface pidstall_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        operation;
    logic [pidstall_pkg::POS_W-1:0]    position_sample;
    logic [pidstall_pkg::CUR_W-1:0]    current_sample;
    logic                              current_due;
    logic signed [pidstall_pkg::OFS_W-1:0] target_or_offset;
    logic [pidstall_pkg::STR_W-1:0]    strength;

    modport source (output valid, operation, position_sample, current_sample,
                    current_due, target_or_offset, strength, input ready);
    modport sink   (input valid, operation, position_sample, current_sample,
                    current_due, target_or_offset, strength, output ready);
endinterface

// ----- src/pidstall_res_if.sv -----
// Result channel: drive command and status beat.
interface pidstall_res_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [pidstall_pkg::DRIVE_W-1:0] drive;
    logic [pidstall_pkg::POS_W-1:0]          target_now;
    logic                                    stall_stopped;
    logic                                    limit_active;

    modport source (output valid, drive, target_now, stall_stopped, limit_active,
                    input ready);
    modport sink   (input valid, drive, target_now, stall_stopped, limit_active,
                    output ready);
endinterface

// ----- src/pid_position_with_stall_stop.sv -----
// Position PID controller with over-current stall stop.
//
// Takes one command beat per clock while it has room and returns exactly
// one result beat per command, in order, once the result side is
// ready. All controller state (target, last position, integral, derivative
// history, stall counter and limits) is updated in the cycle the command is
// accepted, so consecutive beats need no spacing. The drive value then runs
// through a six-stage elastic pipeline; its depth is set by the integral term,
// whose gain_i * sum / 5000 is split as gain_i * (sum / 5000) plus the
// scaled remainder, each with a registered multiply and reciprocal divide.
// Every stage holds its beat independently, so commands keep flowing while a
// finished result waits, until all six stages are occupied. Non-tick
// commands and ticks with zero error report drive 0. Gains and travel_end are
// written through the plain cfg port and must only change while no command
// is in flight.
module pid_position_with_stall_stop
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    pidstall_cmd_if.sink                            cmd,
    pidstall_res_if.source                          res,
    input  logic                                    cfg_we,
    input  logic [pidstall_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pidstall_pkg::CFG_W-1:0]          cfg_data
);

`include "pid_position_with_stall_stop_macros.svh"

    localparam int GAIN_W = pidstall_pkg::GAIN_W;
    localparam int POS_W  = pidstall_pkg::POS_W;

    // configuration registers
    logic [GAIN_W-1:0] gain_p_reg;
    logic [GAIN_W-1:0] gain_i_reg;
    logic [GAIN_W-1:0] gain_d_reg;
    logic [POS_W-1:0]  travel_end_reg;

    logic                              take;
    logic                              pipe_ready;
    pidstall_pkg::item_t               item;
    pidstall_pkg::result_t             result;
    logic [pidstall_pkg::STAGES-1:0]   stage_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            travel_end_reg <= pidstall_pkg::TRAVEL_END_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pidstall_pkg::CFG_GAIN_P:     gain_p_reg     <= cfg_data;
                pidstall_pkg::CFG_GAIN_I:     gain_i_reg     <= cfg_data;
                pidstall_pkg::CFG_GAIN_D:     gain_d_reg     <= cfg_data;
                pidstall_pkg::CFG_TRAVEL_END: travel_end_reg <= cfg_data[POS_W-1:0];
                default:                      gain_p_reg     <= gain_p_reg;
            endcase
        end
    end

    // command beat accepted: state moves and the item enters the pipeline
    assign take      = cmd.valid && pipe_ready;
    assign cmd.ready = pipe_ready;

    pidstall_ctrl u_ctrl
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (take),
        .operation        (cmd.operation),
        .position_sample  (cmd.position_sample),
        .current_sample   (cmd.current_sample),
        .current_due      (cmd.current_due),
        .target_or_offset (cmd.target_or_offset),
        .strength         (cmd.strength),
        .travel_end       (travel_end_reg),
        .item             (item)
    );

    pidstall_drive u_drive
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (cmd.valid),
        .in_ready    (pipe_ready),
        .item        (item),
        .gain_p      (gain_p_reg),
        .gain_i      (gain_i_reg),
        .gain_d      (gain_d_reg),
        .out_valid   (res.valid),
        .out_ready   (res.ready),
        .result      (result),
        .stage_valid (stage_valid)
    );

    assign res.drive         = result.drive;
    assign res.target_now    = result.target_now;
    assign res.stall_stopped = result.stall_stopped;
    assign res.limit_active  = result.limit_active;

    // a stall stop only happens with checking armed
    `PWS_ASSERT(a_trip_needs_limit, clk, rst_n, res.valid |-> (!res.stall_stopped || res.limit_active), "stall stop reported while checking disabled")

    // clamp keeps drive inside the rated range
    `PWS_ASSERT(a_drive_range, clk, rst_n, res.valid |-> (($signed(res.drive) <= pidstall_pkg::DRIVE_LIM) && ($signed(res.drive) >= -pidstall_pkg::DRIVE_LIM)), "drive outside clamp range")

    // a full pipeline with a stalled sink must refuse commands
    `PWS_ASSERT(a_full_backpressure, clk, rst_n, ((&stage_valid) && !res.ready) |-> !cmd.ready, "command accepted with pipeline full and sink stalled")

    // an accepted beat always lands in the first stage
    `PWS_ASSERT_NEXT(a_take_lands, clk, rst_n, take, stage_valid[0], "accepted command lost before first stage")

endmodule

// ----- src/pidstall_ctrl.sv -----
// Controller state and its combinational update, registered for each accepted beat.
module pidstall_ctrl
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              take,
    input  logic [2:0]                        operation,
    input  logic [pidstall_pkg::POS_W-1:0]    position_sample,
    input  logic [pidstall_pkg::CUR_W-1:0]    current_sample,
    input  logic                              current_due,
    input  logic signed [pidstall_pkg::OFS_W-1:0] target_or_offset,
    input  logic [pidstall_pkg::STR_W-1:0]    strength,
    input  logic [pidstall_pkg::POS_W-1:0]    travel_end,
    output pidstall_pkg::item_t               item
);

    localparam int POS_W = pidstall_pkg::POS_W;
    localparam int INT_W = pidstall_pkg::INT_W;
    localparam int CNT_W = pidstall_pkg::CNT_W;

    logic [POS_W-1:0]              target_reg, target_next;
    logic [POS_W-1:0]              last_reg, last_next;
    logic signed [POS_W:0]         prev_err_reg, prev_err_next;
    logic signed [INT_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]              over_reg, over_next;
    logic                          limit_on_reg, limit_on_next;
    logic [pidstall_pkg::STR_W-1:0] climit_reg, climit_next;
    logic [CNT_W-1:0]              trips_reg, trips_next;

    logic [pidstall_pkg::CUR_W-1:0] cur_eff;
    logic [CNT_W-1:0]              over_inc;
    logic [POS_W-1:0]              tick_tgt;
    logic signed [POS_W:0]         err;
    logic signed [INT_W:0]         sum_wide;
    logic signed [INT_W-1:0]       sum_sat;
    logic signed [POS_W+1:0]       derr;
    logic signed [POS_W+1:0]       rel_tgt;
    logic                          tripped;

    // over-current tally; samples above the valid range read as zero
    always_comb
    begin
        cur_eff  = (current_sample > pidstall_pkg::CUR_VALID_MAX) ? '0 : current_sample;
        over_inc = (over_reg == pidstall_pkg::COUNT_MAX) ? over_reg : over_reg + 1'b1;
    end

    // tick path: stall check then error terms
    always_comb
    begin
        tick_tgt  = target_reg;
        over_next = over_reg;
        tripped   = 1'b0;
        if (operation == pidstall_pkg::OP_TICK)
        begin
            if (limit_on_reg)
            begin
                if (current_due && (cur_eff > {2'b00, climit_reg}))
                begin
                    if (over_inc >= trips_reg)
                    begin
                        tick_tgt  = last_reg;
                        over_next = '0;
                        tripped   = 1'b1;
                    end
                    else
                    begin
                        over_next = over_inc;
                    end
                end
            end
            else
            begin
                over_next = '0;
            end
        end
        err      = $signed({1'b0, tick_tgt}) - $signed({1'b0, position_sample});
        sum_wide = $signed({sum_reg[INT_W-1], sum_reg}) + (INT_W+1)'(err);
        if (sum_wide[INT_W] != sum_wide[INT_W-1])
            sum_sat = sum_wide[INT_W] ? {1'b1, {(INT_W-1){1'b0}}}
                                      : {1'b0, {(INT_W-1){1'b1}}};
        else
            sum_sat = sum_wide[INT_W-1:0];
        derr    = (POS_W+2)'(err) - (POS_W+2)'(prev_err_reg);
        rel_tgt = $signed({2'b00, last_reg}) + (POS_W+2)'(target_or_offset);
    end

    always_comb
    begin
        target_next   = target_reg;
        last_next     = last_reg;
        prev_err_next = prev_err_reg;
        sum_next      = sum_reg;
        limit_on_next = limit_on_reg;
        climit_next   = climit_reg;
        trips_next    = trips_reg;
        case (operation)
            pidstall_pkg::OP_TICK:
            begin
                target_next   = tick_tgt;
                last_next     = position_sample;
                prev_err_next = err;
                sum_next      = sum_sat;
            end
            pidstall_pkg::OP_MOVE_ABS:
            begin
                limit_on_next = 1'b1;
                climit_next   = pidstall_pkg::LIMIT_ARMED;
                trips_next    = pidstall_pkg::TRIPS_ARMED;
                if (!target_or_offset[POS_W])
                    target_next = target_or_offset[POS_W-1:0];
            end
            pidstall_pkg::OP_MOVE_REL:
            begin
                limit_on_next = 1'b1;
                climit_next   = pidstall_pkg::LIMIT_ARMED;
                trips_next    = pidstall_pkg::TRIPS_ARMED;
                if (!rel_tgt[POS_W+1] && !rel_tgt[POS_W])
                    target_next = rel_tgt[POS_W-1:0];
            end
            pidstall_pkg::OP_MOVE_HIT:
            begin
                limit_on_next = 1'b1;
                climit_next   = strength;
                target_next   = travel_end;
                // weaker pushes trip sooner
                if (strength < 8'd10)
                    trips_next = 4'd1;
                else if (strength < 8'd20)
                    trips_next = 4'd2;
                else if (strength < 8'd60)
                    trips_next = 4'd3;
                else if (strength < 8'd100)
                    trips_next = 4'd5;
                else
                    trips_next = 4'd8;
            end
            pidstall_pkg::OP_STOP:
            begin
                target_next = last_reg;
            end
            default:
            begin
                target_next = target_reg;
            end
        endcase
    end

    always_comb
    begin
        item.calc    = (operation == pidstall_pkg::OP_TICK) && (err != '0);
        item.err     = err;
        item.sum     = sum_sat;
        item.derr    = derr;
        item.target  = target_next;
        item.tripped = tripped;
        item.limit   = limit_on_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            last_reg     <= '0;
            prev_err_reg <= '0;
            sum_reg      <= '0;
            over_reg     <= '0;
            limit_on_reg <= 1'b0;
            climit_reg   <= pidstall_pkg::LIMIT_RST;
            trips_reg    <= pidstall_pkg::TRIPS_RST;
        end
        else if (take)
        begin
            target_reg   <= target_next;
            last_reg     <= last_next;
            prev_err_reg <= prev_err_next;
            sum_reg      <= sum_next;
            over_reg     <= over_next;
            limit_on_reg <= limit_on_next;
            climit_reg   <= climit_next;
            trips_reg    <= trips_next;
        end
    end

endmodule

// ----- src/pidstall_drive.sv -----
// Six-stage elastic pipeline computing the clamped PID drive.
module pidstall_drive
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  pidstall_pkg::item_t                    item,
    input  logic [pidstall_pkg::GAIN_W-1:0]        gain_p,
    input  logic [pidstall_pkg::GAIN_W-1:0]        gain_i,
    input  logic [pidstall_pkg::GAIN_W-1:0]        gain_d,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output pidstall_pkg::result_t                  result,
    output logic [pidstall_pkg::STAGES-1:0]        stage_valid
);

    localparam int STAGES  = pidstall_pkg::STAGES;
    localparam int POS_W   = pidstall_pkg::POS_W;
    localparam int INT_W   = pidstall_pkg::INT_W;
    localparam int GAIN_W  = pidstall_pkg::GAIN_W;
    localparam int Q_W     = pidstall_pkg::Q_W;
    localparam int REM_W   = pidstall_pkg::REM_W;
    localparam int DQ_W    = pidstall_pkg::DQ_W;
    localparam int P_W     = GAIN_W + POS_W + 2;
    localparam int DM_W    = GAIN_W + POS_W + 1;
    localparam int IQ_W    = GAIN_W + Q_W;
    localparam int IR_W    = GAIN_W + REM_W;
    localparam int IT_W    = IQ_W + 2;
    localparam int TOT_W   = IT_W + 2;

    typedef struct packed {
        logic             calc;
        logic [POS_W-1:0] target;
        logic             tripped;
        logic             limit;
    } meta_t;

    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES-1:0] rdy;

    // stage 0: accepted item
    pidstall_pkg::item_t a_reg;

    // stage 1
    meta_t                 b_meta_reg, b_meta_next;
    logic [Q_W-1:0]        b_qs_reg, b_qs_next;
    logic [INT_W-1:0]      b_mag_reg, b_mag_next;
    logic                  b_isign_reg, b_isign_next;
    logic signed [P_W-1:0] b_p_reg, b_p_next;
    logic [DM_W-1:0]       b_dmag_reg, b_dmag_next;
    logic                  b_dsign_reg, b_dsign_next;

    // stage 2
    meta_t                 c_meta_reg;
    logic [REM_W-1:0]      c_r_reg, c_r_next;
    logic [IQ_W-1:0]       c_iq_reg, c_iq_next;
    logic [DQ_W-1:0]       c_dq_reg, c_dq_next;
    logic                  c_isign_reg;
    logic                  c_dsign_reg;
    logic signed [P_W-1:0] c_p_reg;

    // stage 3
    meta_t                 d_meta_reg;
    logic [IR_W-1:0]       d_ir_reg, d_ir_next;
    logic [IQ_W-1:0]       d_iq_reg;
    logic [DQ_W-1:0]       d_dq_reg;
    logic                  d_isign_reg;
    logic                  d_dsign_reg;
    logic signed [P_W-1:0] d_p_reg;

    // stage 4
    meta_t                 e_meta_reg;
    logic [Q_W-1:0]        e_irq_reg, e_irq_next;
    logic [IQ_W-1:0]       e_iq_reg;
    logic [DQ_W-1:0]       e_dq_reg;
    logic                  e_isign_reg;
    logic                  e_dsign_reg;
    logic signed [P_W-1:0] e_p_reg;

    // stage 5: output
    pidstall_pkg::result_t res_reg, res_next;

    logic [INT_W-1:0]        sum_mag;
    logic [POS_W:0]          derr_mag;
    logic [INT_W-1:0]        rem_full;
    logic [IQ_W:0]           imag;
    logic signed [IT_W-1:0]  isig, iterm;
    logic signed [DQ_W:0]    dsig, dterm;
    logic signed [TOT_W-1:0] total;

    // a stage may load when empty or when its content moves on
    always_comb
    begin
        rdy[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
            rdy[i] = !valid_reg[i] || rdy[i+1];
        valid_next = valid_reg;
        for (int i = 0; i < STAGES; i++)
        begin
            if (rdy[i])
                valid_next[i] = (i == 0) ? in_valid : valid_reg[i-1];
        end
    end

    // stage 1: magnitudes, |sum| / 5000, P and D products
    always_comb
    begin
        sum_mag       = a_reg.sum[INT_W-1] ? $unsigned(-a_reg.sum) : $unsigned(a_reg.sum);
        derr_mag      = a_reg.derr[POS_W+1] ? POS_W'(0) + (POS_W+1)'(-a_reg.derr)
                                            : a_reg.derr[POS_W:0];
        b_meta_next   = '{calc: a_reg.calc, target: a_reg.target,
                          tripped: a_reg.tripped, limit: a_reg.limit};
        b_qs_next     = pidstall_pkg::div625(sum_mag[INT_W-1:3]);
        b_mag_next    = sum_mag;
        b_isign_next  = a_reg.sum[INT_W-1];
        b_p_next      = $signed({1'b0, gain_p}) * a_reg.err;
        b_dmag_next   = gain_d * derr_mag;
        b_dsign_next  = a_reg.derr[POS_W+1];
    end

    // stage 2: remainder, gain_i * quotient, D divide
    always_comb
    begin
        rem_full  = b_mag_reg - INT_W'(b_qs_reg) * INT_W'(pidstall_pkg::I_DIVISOR);
        c_r_next  = rem_full[REM_W-1:0];
        c_iq_next = gain_i * b_qs_reg;
        c_dq_next = pidstall_pkg::div25({1'b0, b_dmag_reg[DM_W-1:1]});
    end

    // stage 3: gain_i * remainder
    always_comb
    begin
        d_ir_next = gain_i * c_r_reg;
    end

    // stage 4: remainder product / 5000
    always_comb
    begin
        e_irq_next = pidstall_pkg::div625({3'b000, d_ir_reg[IR_W-1:3]});
    end

    // stage 5: sum of terms and clamp
    always_comb
    begin
        imag  = (IQ_W+1)'(e_iq_reg) + (IQ_W+1)'(e_irq_reg);
        isig  = $signed({1'b0, imag});
        iterm = e_isign_reg ? -isig : isig;
        dsig  = $signed({1'b0, e_dq_reg});
        dterm = e_dsign_reg ? -dsig : dsig;
        total = TOT_W'(iterm) + TOT_W'(dterm) + TOT_W'(e_p_reg);
        res_next.target_now    = e_meta_reg.target;
        res_next.stall_stopped = e_meta_reg.tripped;
        res_next.limit_active  = e_meta_reg.limit;
        if (!e_meta_reg.calc)
            res_next.drive = '0;
        else if (total > TOT_W'(pidstall_pkg::DRIVE_LIM))
            res_next.drive = pidstall_pkg::DRIVE_LIM;
        else if (total < -TOT_W'(pidstall_pkg::DRIVE_LIM))
            res_next.drive = -pidstall_pkg::DRIVE_LIM;
        else
            res_next.drive = total[pidstall_pkg::DRIVE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
            a_reg <= item;
        if (rdy[1])
        begin
            b_meta_reg  <= b_meta_next;
            b_qs_reg    <= b_qs_next;
            b_mag_reg   <= b_mag_next;
            b_isign_reg <= b_isign_next;
            b_p_reg     <= b_p_next;
            b_dmag_reg  <= b_dmag_next;
            b_dsign_reg <= b_dsign_next;
        end
        if (rdy[2])
        begin
            c_meta_reg  <= b_meta_reg;
            c_r_reg     <= c_r_next;
            c_iq_reg    <= c_iq_next;
            c_dq_reg    <= c_dq_next;
            c_isign_reg <= b_isign_reg;
            c_dsign_reg <= b_dsign_reg;
            c_p_reg     <= b_p_reg;
        end
        if (rdy[3])
        begin
            d_meta_reg  <= c_meta_reg;
            d_ir_reg    <= d_ir_next;
            d_iq_reg    <= c_iq_reg;
            d_dq_reg    <= c_dq_reg;
            d_isign_reg <= c_isign_reg;
            d_dsign_reg <= c_dsign_reg;
            d_p_reg     <= c_p_reg;
        end
        if (rdy[4])
        begin
            e_meta_reg  <= d_meta_reg;
            e_irq_reg   <= e_irq_next;
            e_iq_reg    <= d_iq_reg;
            e_dq_reg    <= d_dq_reg;
            e_isign_reg <= d_isign_reg;
            e_dsign_reg <= d_dsign_reg;
            e_p_reg     <= d_p_reg;
        end
        if (rdy[5])
            res_reg <= res_next;
    end

    assign in_ready    = rdy[0];
    assign out_valid   = valid_reg[STAGES-1];
    assign result      = res_reg;
    assign stage_valid = valid_reg;

endmodule

// ----- sim/pid_drive_checker.sv -----
// Beat monitor, controller predictor and result comparison for the position PID block.
`timescale 1ns / 1ps

module pid_drive_checker
    import pidstall_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    pidstall_cmd_if              cmd,
    pidstall_res_if              res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   beats_checked,
    output int                   trips_seen,
    output int                   clamps_seen
);

    localparam longint INTEG_DIV = 5000;
    localparam longint DERIV_DIV = 50;
    localparam longint DRIVE_MAX = 400;
    localparam longint SUM_HI    = (longint'(1) <<< (INT_W - 1)) - 1;
    localparam longint SUM_LO    = -SUM_HI - 1;
    localparam longint POS_TOP   = (longint'(1) <<< POS_W) - 1;
    localparam int     SHOW_MAX  = 10;

    // model copy of the controller state and registers
    logic [POS_W-1:0]  tgt_pos, last_pos, end_pos;
    logic [GAIN_W-1:0] kp, ki, kd;
    longint            prev_err, err_sum;
    int unsigned       over_cnt, cur_limit, trips_need;
    logic              limit_on;

    result_t pending_results[$];

    function automatic result_t advance_controller(input logic [2:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [CUR_W-1:0] cur,
                                                   input logic due,
                                                   input logic signed [OFS_W-1:0] arg,
                                                   input logic [STR_W-1:0] str);
        result_t     r;
        longint      e, de, acc, goal;
        int unsigned amp;
        r = '0;
        case (op)
            OP_TICK: begin
                if (limit_on) begin
                    if (due) begin
                        amp = (cur > CUR_VALID_MAX) ? 0 : cur;
                        if (amp > cur_limit) begin
                            if (over_cnt < COUNT_MAX)
                                over_cnt++;
                            if (over_cnt >= trips_need) begin
                                tgt_pos         = last_pos;
                                over_cnt        = 0;
                                r.stall_stopped = 1'b1;
                            end
                        end
                    end
                end
                else begin
                    over_cnt = 0;
                end
                last_pos = pos;
                e        = longint'(tgt_pos) - longint'(pos);
                acc      = err_sum + e;
                if (acc > SUM_HI)
                    acc = SUM_HI;
                if (acc < SUM_LO)
                    acc = SUM_LO;
                err_sum  = acc;
                de       = e - prev_err;
                prev_err = e;
                if (e != 0) begin
                    acc = longint'(kp) * e + (longint'(ki) * err_sum) / INTEG_DIV
                        + (longint'(kd) * de) / DERIV_DIV;
                    if (acc > DRIVE_MAX)
                        acc = DRIVE_MAX;
                    if (acc < -DRIVE_MAX)
                        acc = -DRIVE_MAX;
                    r.drive = DRIVE_W'(acc);
                end
            end
            OP_MOVE_ABS, OP_MOVE_REL: begin
                limit_on   = 1'b1;
                cur_limit  = LIMIT_ARMED;
                trips_need = TRIPS_ARMED;
                goal = longint'(arg);
                if (op == OP_MOVE_REL)
                    goal = goal + longint'(last_pos);
                if (goal >= 0 && goal <= POS_TOP)
                    tgt_pos = POS_W'(goal);
            end
            OP_MOVE_HIT: begin
                limit_on  = 1'b1;
                cur_limit = str;
                tgt_pos   = end_pos;
                if (str < 10)
                    trips_need = 1;
                else if (str < 20)
                    trips_need = 2;
                else if (str < 60)
                    trips_need = 3;
                else if (str < 100)
                    trips_need = 5;
                else
                    trips_need = 8;
            end
            OP_STOP: tgt_pos = last_pos;
            default: ;
        endcase
        r.target_now   = tgt_pos;
        r.limit_active = limit_on;
        return r;
    endfunction

    task automatic log_miss(input string why, input result_t want, input result_t got);
        fail_count++;
        if (fail_count <= SHOW_MAX)
            $display("%t %s: expected drive %0d target %0d stall %0b limit %0b, got drive %0d target %0d stall %0b limit %0b",
                     $time, why, want.drive, want.target_now, want.stall_stopped,
                     want.limit_active, got.drive, got.target_now, got.stall_stopped,
                     got.limit_active);
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        result_t want, got;
        if (!rst_n) begin
            tgt_pos    = '0;
            last_pos   = '0;
            end_pos    = TRAVEL_END_RST;
            kp         = '0;
            ki         = '0;
            kd         = '0;
            prev_err   = 0;
            err_sum    = 0;
            over_cnt   = 0;
            cur_limit  = LIMIT_RST;
            trips_need = TRIPS_RST;
            limit_on   = 1'b0;
            pending_results.delete();
            fail_count    = 0;
            beats_checked = 0;
            trips_seen    = 0;
            clamps_seen   = 0;
            pending      <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_GAIN_P:     kp = cfg_data;
                    CFG_GAIN_I:     ki = cfg_data;
                    CFG_GAIN_D:     kd = cfg_data;
                    CFG_TRAVEL_END: end_pos = cfg_data[POS_W-1:0];
                    default: ;
                endcase
            end
            // result beat first: it always belongs to an older command
            if (res.valid && res.ready) begin
                got.drive         = res.drive;
                got.target_now    = res.target_now;
                got.stall_stopped = res.stall_stopped;
                got.limit_active  = res.limit_active;
                if (pending_results.size() == 0) begin
                    log_miss("unexpected result beat", '0, got);
                end
                else begin
                    want = pending_results.pop_front();
                    beats_checked++;
                    if (want.stall_stopped)
                        trips_seen++;
                    if (want.drive == DRIVE_LIM || want.drive == -DRIVE_LIM)
                        clamps_seen++;
                    if (got !== want)
                        log_miss("result mismatch", want, got);
                end
            end
            if (cmd.valid && cmd.ready)
                pending_results.push_back(advance_controller(cmd.operation,
                    cmd.position_sample, cmd.current_sample, cmd.current_due,
                    cmd.target_or_offset, cmd.strength));
            pending <= pending_results.size();
        end
    end

endmodule

// ----- sim/pid_position_with_stall_stop_tb.sv -----
// Top-level testbench: clock, reset, command and register stimulus, and the verdict.
`timescale 1ns / 1ps

module pid_position_with_stall_stop_tb;
    import pidstall_pkg::*;

    // codes 5..7 are not operations; the block must ignore them
    localparam logic [2:0] OP_RSVD_LO = 3'd5;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;

    localparam int RESET_CYCLES = 7;
    localparam int HOLD_CYCLES  = 60;   // long result-side hold-off
    localparam int DRAIN_SLACK  = 12;   // pipeline depth plus margin
    localparam int TIMEOUT_NS   = 2_000_000;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int fail_count, pending, beats_checked, trips_seen, clamps_seen;

    // stimulus state; no_idle, long_hold_req and holds_done are shared with the result side
    bit no_idle;        // suppresses random gaps on both sides
    bit long_hold_req;  // asks the result side for one long hold-off
    int accepted;       // command beats that carry a real operation
    int holds_done;
    int travel_now;     // travel_end as last programmed
    int pos_now;        // simulated actuator position
    int aim;            // where the last move should take it

    pidstall_cmd_if cmd_ch ();
    pidstall_res_if res_ch ();

    pid_position_with_stall_stop u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pid_drive_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_ch),
        .res           (res_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked),
        .trips_seen    (trips_seen),
        .clamps_seen   (clamps_seen)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Mostly back-to-back, some short gaps, an occasional long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Current sample spread: mostly below or just above the usual limits,
    // some above the 180 validity cap, the odd full-scale value.
    function automatic logic [CUR_W-1:0] pick_current();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return CUR_W'($urandom_range(0, 80));
        else if (r < 7)
            return CUR_W'($urandom_range(81, 180));
        else if (r < 8)
            return CUR_W'($urandom_range(181, 1023));
        else if (r < 9)
            return '1;
        else
            return CUR_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic signed [OFS_W-1:0] any_offset();
        int v;
        v = int'($urandom_range(0, 2046)) - 1023;
        return v[OFS_W-1:0];
    endfunction

    // One command beat. Called on a clock edge; returns on the accepting edge,
    // with valid still high so the next beat can follow without a bubble.
    task automatic send_cmd(input logic [2:0] op, input int pos, input int cur,
                            input bit due, input int arg, input int str);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid            <= 1'b1;
        cmd_ch.operation        <= op;
        cmd_ch.position_sample  <= POS_W'(pos);
        cmd_ch.current_sample   <= CUR_W'(cur);
        cmd_ch.current_due      <= due;
        cmd_ch.target_or_offset <= OFS_W'(arg);
        cmd_ch.strength         <= STR_W'(str);
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        if (op <= OP_STOP)
            accepted++;
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // All four registers, one write per cycle; only called with nothing in flight.
    task automatic set_regs(input logic [CFG_W-1:0] kp, input logic [CFG_W-1:0] ki,
                            input logic [CFG_W-1:0] kd, input int stop_at);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GAIN_P;
        cfg_data  <= kp;
        @(posedge clk);
        cfg_index <= CFG_GAIN_I;
        cfg_data  <= ki;
        @(posedge clk);
        cfg_index <= CFG_GAIN_D;
        cfg_data  <= kd;
        @(posedge clk);
        cfg_index <= CFG_TRAVEL_END;
        cfg_data  <= CFG_W'(stop_at);
        @(posedge clk);
        cfg_we    <= 1'b0;
        travel_now = stop_at;
    endtask

    task automatic tick_toward_aim();
        int step;
        step = $urandom_range(0, 60);
        if (pos_now < aim)
            pos_now += step;
        else
            pos_now -= step;
        pos_now += int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 19) == 0)
            pos_now = $urandom_range(0, 1023);
        if (pos_now < 0)
            pos_now = 0;
        if (pos_now > 1023)
            pos_now = 1023;
        send_cmd(OP_TICK, pos_now, pick_current(), $urandom_range(0, 1), any_offset(),
                 $urandom_range(0, 255));
    endtask

    // A move or stop followed by a run of control ticks, most of the time; otherwise
    // a raw beat with every field random, reserved codes included.
    task automatic run_episode();
        int kind, n_ticks, arg, str;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            send_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 1023),
                     $urandom_range(0, 1023), $urandom_range(0, 1), any_offset(),
                     $urandom_range(0, 255));
            return;
        end
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            // mostly in range, sometimes a random signed value; a negative target must be dropped
            arg = ($urandom_range(0, 9) == 0) ? int'(any_offset()) : $urandom_range(0, 1023);
            if (arg >= 0)
                aim = arg;
            send_cmd(OP_MOVE_ABS, 0, 0, 0, arg, 0);
        end
        else if (kind < 60) begin
            arg = ($urandom_range(0, 4) == 0) ? int'(any_offset())
                                               : int'($urandom_range(0, 300)) - 150;
            if (pos_now + arg >= 0 && pos_now + arg <= 1023)
                aim = pos_now + arg;
            send_cmd(OP_MOVE_REL, 0, 0, 0, arg, 0);
        end
        else if (kind < 85) begin
            str = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 255);
            aim = travel_now;
            send_cmd(OP_MOVE_HIT, 0, 0, 0, any_offset(), str);
        end
        else begin
            aim = pos_now;
            send_cmd(OP_STOP, 0, 0, 0, any_offset(), $urandom_range(0, 255));
        end
        n_ticks = $urandom_range(2, 10);
        repeat (n_ticks) begin
            tick_toward_aim();
            // broken sequences: a stray stop or reserved code mid-run
            if ($urandom_range(0, 29) == 0)
                send_cmd(OP_STOP, 0, 0, 0, 0, 0);
            else if ($urandom_range(0, 29) == 0)
                send_cmd(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), pos_now, 0, 0, 0, 0);
        end
    endtask

    // Result side: random stalls, or one long hold-off when asked.
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else begin
                res_ch.ready <= 1'b1;
                if (!no_idle)
                    hold_left = pick_gap();
            end
        end
    end

    initial
    begin : stimulus
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_index               <= CFG_GAIN_P;
        cfg_data                <= '0;
        cmd_ch.valid            <= 1'b0;
        cmd_ch.operation        <= OP_TICK;
        cmd_ch.position_sample  <= '0;
        cmd_ch.current_sample   <= '0;
        cmd_ch.current_due      <= 1'b0;
        cmd_ch.target_or_offset <= '0;
        cmd_ch.strength         <= '0;
        no_idle       = 1'b0;
        long_hold_req = 1'b0;
        accepted      = 0;
        holds_done    = 0;
        pos_now       = 0;
        aim           = 0;
        travel_now    = TRAVEL_END_RST;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: field extremes, every operation, the special cases ----
        set_regs(16'd2, 16'd300, 16'd150, 1023);
        send_cmd(OP_TICK, 0, 1023, 1, 0, 0);         // zero error, checking still off
        send_cmd(OP_MOVE_ABS, 0, 0, 0, 1023, 0);
        send_cmd(OP_TICK, 0, 0, 0, 0, 0);            // large positive error, clamps high
        send_cmd(OP_MOVE_ABS, 0, 0, 0, -1023, 0);    // out of range, target kept
        send_cmd(OP_MOVE_ABS, 0, 0, 0, 0, 0);
        send_cmd(OP_TICK, 1023, 0, 0, 0, 0);         // clamps low
        send_cmd(OP_MOVE_REL, 0, 0, 0, 1023, 0);     // past the top, dropped
        send_cmd(OP_MOVE_REL, 0, 0, 0, -1023, 0);    // lands exactly on zero
        // move-until-hit strength brackets, edges on both sides
        send_cmd(OP_MOVE_HIT, 0, 0, 0, 0, 255);
        send_cmd(OP_MOVE_HIT, 0, 0, 0, 0, 100);
        send_cmd(OP_MOVE_HIT, 0, 0, 0, 0, 99);
        send_cmd(OP_MOVE_HIT, 0, 0, 0, 0, 60);
        send_cmd(OP_MOVE_HIT, 0, 0, 0, 0, 59);
        send_cmd(OP_MOVE_HIT, 0, 0, 0, 0, 0);        // limit 0, one trip needed
        send_cmd(OP_TICK, 500, 181, 1, 0, 0);        // above the cap: reads as zero
        send_cmd(OP_TICK, 510, 1, 1, 0, 0);          // trips at once, target = 500
        send_cmd(OP_MOVE_HIT, 0, 0, 0, 0, 9);
        send_cmd(OP_MOVE_HIT, 0, 0, 0, 0, 10);       // two trips needed
        send_cmd(OP_TICK, 600, 180, 1, 0, 0);        // the cap itself still counts
        send_cmd(OP_TICK, 620, 180, 1, 0, 0);        // second count trips
        send_cmd(OP_TICK, 640, 1023, 0, 0, 0);       // sample not due
        send_cmd(OP_STOP, 0, 0, 0, 0, 0);
        send_cmd(OP_RSVD_LO, 100, 0, 1, 1023, 255);
        send_cmd(OP_RSVD_HI, 900, 1023, 1, -1023, 0);
        pos_now = 640;
        aim     = 640;
        drain();

        // ---- random, moderate gains ----
        set_regs(16'd1, 16'd40, 16'd200, 1023);
        while (accepted < 150)
            run_episode();

        // ---- fill the pipeline: result side holds off, commands keep coming ----
        long_hold_req = 1'b1;
        no_idle       = 1'b1;
        repeat (30) tick_toward_aim();
        no_idle = 1'b0;
        drain();

        // ---- all gains zero, travel end at the bottom ----
        set_regs(16'd0, 16'd0, 16'd0, 0);
        while (accepted < 250)
            run_episode();
        drain();

        // ---- all gains at full scale, mid travel end ----
        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 512);
        while (accepted < 350)
            run_episode();
        drain();

        // ---- random small gains and travel end, first with no idling on either side ----
        set_regs(CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(0, 2000)),
                 CFG_W'($urandom_range(0, 500)), $urandom_range(0, 1023));
        no_idle = 1'b1;
        while (accepted < 410)
            run_episode();
        no_idle = 1'b0;
        while (accepted < 480)
            run_episode();
        drain();

        $display("Checked %0d result beats over five register settings, %0d long hold-off(s).",
                 beats_checked, holds_done);
        $display("Stall trips predicted: %0d, drives at the clamp: %0d, failures: %0d.",
                 trips_seen, clamps_seen, fail_count);
        if (fail_count == 0)
            $display("** pid_position_with_stall_stop: PASSED **");
        else
            $display("** pid_position_with_stall_stop: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still expected.", pending);
        $display("** pid_position_with_stall_stop: FAILED **");
        $finish;
    end

endmodule
